// ===== rtl/pds_pkg.sv =====
// Shared types, codes and helpers for the pointer to d-pad steering core.
// Used by pds_axis, pds_probe and pointer_to_dpad_steering_core. No dependencies.
package pds_pkg;

	// key bit positions in key_mask
	localparam logic [5:0] KEY_A     = 6'h01;
	localparam logic [5:0] KEY_B     = 6'h02;
	localparam logic [5:0] KEY_RIGHT = 6'h04;
	localparam logic [5:0] KEY_LEFT  = 6'h08;
	localparam logic [5:0] KEY_UP    = 6'h10;
	localparam logic [5:0] KEY_DOWN  = 6'h20;

	// register indexes on the configuration port
	localparam logic [1:0] REG_INIT_DEADBAND = 2'd0;
	localparam logic [1:0] REG_PRESS_STALL   = 2'd1;
	localparam logic [1:0] REG_RELEASE_HOLD  = 2'd2;
	localparam logic [1:0] REG_PROBE_PERIOD  = 2'd3;

	// register reset values
	localparam logic [7:0] INIT_DEADBAND_RST = 8'd4;
	localparam logic [7:0] PRESS_STALL_RST   = 8'd8;
	localparam logic [7:0] RELEASE_HOLD_RST  = 8'd1;
	localparam logic [7:0] PROBE_PERIOD_RST  = 8'd8;

	// smallest deadband once a step has been learned
	localparam logic [8:0] MIN_DEADBAND = 9'd2;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_PRESS   = 2'd1,
		PH_RELEASE = 2'd2,
		PH_BLOCKED = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		DIR_NONE = 2'd0,
		DIR_POS  = 2'd1,
		DIR_NEG  = 2'd2
	} dir_t;

	typedef struct packed {
		logic [7:0] init_deadband;
		logic [7:0] press_stall_frames;
		logic [7:0] release_hold_frames;
		logic [7:0] probe_period;
	} cfg_t;

	// per-frame command to an axis: step = a beat is being processed
	typedef struct packed {
		logic step;
		logic clear;
	} axis_ctl_t;

	// per-frame command to the probe: clear = back to reset, run = count and pulse
	typedef struct packed {
		logic step;
		logic clear;
		logic run;
	} probe_ctl_t;

	function automatic logic [7:0] sat_inc(input logic [7:0] v);
		return (v == 8'hFF) ? v : v + 8'd1;
	endfunction

endpackage

// ===== rtl/pds_axis.sv =====
// One axis of closed-loop steering: idle/press/release/blocked machine with learned step.
// Depends on pds_pkg.
module pds_axis #(
	parameter int unsigned BLOCK_COOLDOWN = 30
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pds_pkg::axis_ctl_t  ctl,
	input  pds_pkg::cfg_t       cfg,
	input  logic signed [9:0]   err,
	input  logic [9:0]          world,
	output pds_pkg::dir_t       key_dir
);

	localparam logic [7:0] COOLDOWN = 8'(BLOCK_COOLDOWN);

	pds_pkg::phase_t phase_q, phase_d;
	pds_pkg::dir_t   dir_q, dir_d;
	logic [7:0]      press_q, press_d;
	logic [7:0]      rel_q, rel_d;
	logic [7:0]      cool_q, cool_d;
	logic [9:0]      start_q, start_d;
	logic [9:0]      learn_q, learn_d;

	logic [9:0]        abs_err;
	logic [8:0]        half;
	logic [8:0]        dband;
	logic signed [10:0] wdiff;
	logic [9:0]        abs_wdiff;
	pds_pkg::dir_t     wanted;

	assign abs_err   = err[9] ? 10'(-err) : 10'(err);
	assign half      = learn_q[9:1];
	assign dband     = (learn_q == '0) ? {1'b0, cfg.init_deadband}
	                 : ((half < pds_pkg::MIN_DEADBAND) ? pds_pkg::MIN_DEADBAND : half);
	assign wdiff     = $signed({1'b0, world}) - $signed({1'b0, start_q});
	assign abs_wdiff = wdiff[10] ? 10'(-wdiff) : 10'(wdiff);
	assign wanted    = err[9] ? pds_pkg::DIR_NEG : pds_pkg::DIR_POS;

	always_comb begin
		pds_pkg::phase_t ph1;
		logic [7:0]      cnt;
		phase_d = phase_q;
		dir_d   = dir_q;
		press_d = press_q;
		rel_d   = rel_q;
		cool_d  = cool_q;
		start_d = start_q;
		learn_d = learn_q;
		key_dir = pds_pkg::DIR_NONE;
		ph1     = phase_q;
		cnt     = '0;
		if (ctl.step && ctl.clear) begin
			phase_d = pds_pkg::PH_IDLE;
			dir_d   = pds_pkg::DIR_NONE;
			press_d = '0;
			rel_d   = '0;
			cool_d  = '0;
			start_d = '0;
			learn_d = '0;
		end else if (ctl.step) begin
			if (abs_err <= {1'b0, dband}) begin
				// inside deadband: settle
				phase_d = pds_pkg::PH_IDLE;
				dir_d   = pds_pkg::DIR_NONE;
				cool_d  = '0;
			end else begin
				// direction change aborts a press or a block
				if (phase_q == pds_pkg::PH_BLOCKED && wanted != dir_q) begin
					ph1    = pds_pkg::PH_IDLE;
					cool_d = '0;
				end
				if (phase_q == pds_pkg::PH_PRESS && wanted != dir_q)
					ph1 = pds_pkg::PH_IDLE;
				unique case (ph1)
					pds_pkg::PH_IDLE: begin
						phase_d = pds_pkg::PH_PRESS;
						dir_d   = wanted;
						press_d = '0;
						start_d = world;
						key_dir = wanted;
					end
					pds_pkg::PH_PRESS: begin
						if (world != start_q) begin
							learn_d = abs_wdiff;
							phase_d = pds_pkg::PH_RELEASE;
							rel_d   = '0;
						end else begin
							cnt     = pds_pkg::sat_inc(press_q);
							press_d = cnt;
							if (cnt >= cfg.press_stall_frames) begin
								phase_d = pds_pkg::PH_BLOCKED;
								cool_d  = '0;
							end else begin
								key_dir = dir_q;
							end
						end
					end
					pds_pkg::PH_RELEASE: begin
						cnt   = pds_pkg::sat_inc(rel_q);
						rel_d = cnt;
						if (cnt >= cfg.release_hold_frames)
							phase_d = pds_pkg::PH_IDLE;
					end
					default: begin
						// blocked, same direction still wanted
						cnt    = pds_pkg::sat_inc(cool_q);
						cool_d = cnt;
						if (cnt >= COOLDOWN) begin
							phase_d = pds_pkg::PH_IDLE;
							cool_d  = '0;
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= pds_pkg::PH_IDLE;
			dir_q   <= pds_pkg::DIR_NONE;
			press_q <= '0;
			rel_q   <= '0;
			cool_q  <= '0;
			start_q <= '0;
			learn_q <= '0;
		end else begin
			phase_q <= phase_d;
			dir_q   <= dir_d;
			press_q <= press_d;
			rel_q   <= rel_d;
			cool_q  <= cool_d;
			start_q <= start_d;
			learn_q <= learn_d;
		end
	end

endmodule

// ===== rtl/pds_probe.sv =====
// Open-loop probe: one-frame pulse toward the larger offset from screen centre.
// Depends on pds_pkg.
module pds_probe #(
	parameter int unsigned CENTER_X = 120,
	parameter int unsigned CENTER_Y = 80
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pds_pkg::probe_ctl_t ctl,
	input  logic [7:0]          period,
	input  logic [8:0]          goal_x,
	input  logic [8:0]          goal_y,
	output logic [5:0]          keys
);

	localparam logic signed [9:0] CX = 10'(CENTER_X);
	localparam logic signed [9:0] CY = 10'(CENTER_Y);

	logic [7:0]        count_q, count_d, count_inc;
	logic signed [9:0] dx, dy;
	logic [9:0]        adx, ady;
	logic [5:0]        toward;

	assign dx  = $signed({1'b0, goal_x}) - CX;
	assign dy  = $signed({1'b0, goal_y}) - CY;
	assign adx = dx[9] ? 10'(-dx) : 10'(dx);
	assign ady = dy[9] ? 10'(-dy) : 10'(dy);

	// ties go to the horizontal axis; zero offset counts as positive
	always_comb begin
		if (adx >= ady)
			toward = dx[9] ? pds_pkg::KEY_LEFT : pds_pkg::KEY_RIGHT;
		else
			toward = dy[9] ? pds_pkg::KEY_UP : pds_pkg::KEY_DOWN;
	end

	assign count_inc = pds_pkg::sat_inc(count_q);

	always_comb begin
		count_d = count_q;
		keys    = '0;
		if (ctl.step && ctl.clear) begin
			count_d = '0;
		end else if (ctl.step && ctl.run) begin
			if (count_inc < period) begin
				count_d = count_inc;
			end else begin
				count_d = '0;
				keys    = toward;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			count_q <= '0;
		else
			count_q <= count_d;
	end

endmodule

// ===== rtl/pointer_to_dpad_steering_core.sv =====
// Top level of the pointer to d-pad steering core: input stage, axis and probe units,
// result register and configuration registers. Depends on pds_pkg, pds_axis, pds_probe.
//
// One beat in gives one beat out. A frame is taken into the input stage; as it leaves,
// the single-pass steering logic (two axis machines and the probe counter) forms
// the key mask and updates all state while the result is written into the output
// register, from which it is taken as the result
// beat. One frame can be taken on every cycle: the input stage advances whenever the
// output register is empty or its beat is being taken, so throughput is one frame per
// clock, limited only by the output side. Configuration registers reset to an initial
// deadband of 4, press_stall_frames 8, release_hold_frames 1 and probe_period 8; write
// them only while no frame is in flight.
module pointer_to_dpad_steering_core #(
	parameter int unsigned CENTER_X       = 120,
	parameter int unsigned CENTER_Y       = 80,
	parameter int unsigned BLOCK_COOLDOWN = 30
) (
	input  logic       clk,
	input  logic       arst_n,
	// configuration write port
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	// input channel
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       click_primary,
	input  logic       click_secondary,
	input  logic       pad_held,
	input  logic       pointer_armed,
	input  logic       context_steerable,
	input  logic       marker_found,
	input  logic [8:0] goal_x,
	input  logic [8:0] goal_y,
	input  logic [8:0] marker_x,
	input  logic [8:0] marker_y,
	input  logic [8:0] pan_x,
	input  logic [8:0] pan_y,
	// result channel
	output logic       out_valid,
	input  logic       out_ready,
	output logic [5:0] key_mask,
	output logic       steering_active
);

	pds_pkg::cfg_t cfg_q;

	// input stage
	logic       vld_s1;
	logic       clk_a_s1, clk_b_s1, pad_s1, armed_s1, steer_s1, found_s1;
	logic [8:0] goal_x_s1, goal_y_s1, marker_x_s1, marker_y_s1, pan_x_s1, pan_y_s1;

	// result stage
	logic       vld_s2;
	logic [5:0] key_mask_s2;
	logic       active_s2;

	logic advance;
	logic take_in;

	pds_pkg::axis_ctl_t  axis_ctl;
	pds_pkg::probe_ctl_t probe_ctl;
	logic                disarmed;
	logic                closed_loop;

	logic signed [9:0] err_x, err_y;
	logic [9:0]        world_x, world_y;
	pds_pkg::dir_t     dir_x, dir_y;
	logic [5:0]        probe_keys;
	logic [5:0]        steer_keys;
	logic [5:0]        keys;

	// ---------------------------------------------------------------- handshake
	assign advance  = vld_s1 && (!vld_s2 || out_ready);
	assign in_ready = !vld_s1 || advance;
	assign take_in  = in_valid && in_ready;

	// ---------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.init_deadband       <= pds_pkg::INIT_DEADBAND_RST;
			cfg_q.press_stall_frames  <= pds_pkg::PRESS_STALL_RST;
			cfg_q.release_hold_frames <= pds_pkg::RELEASE_HOLD_RST;
			cfg_q.probe_period        <= pds_pkg::PROBE_PERIOD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pds_pkg::REG_INIT_DEADBAND: cfg_q.init_deadband       <= cfg_data;
				pds_pkg::REG_PRESS_STALL:   cfg_q.press_stall_frames  <= cfg_data;
				pds_pkg::REG_RELEASE_HOLD:  cfg_q.release_hold_frames <= cfg_data;
				default:                    cfg_q.probe_period        <= cfg_data;
			endcase
		end
	end

	// ---------------------------------------------------------------- input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (in_ready)
			vld_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			clk_a_s1    <= click_primary;
			clk_b_s1    <= click_secondary;
			pad_s1      <= pad_held;
			armed_s1    <= pointer_armed;
			steer_s1    <= context_steerable;
			found_s1    <= marker_found;
			goal_x_s1   <= goal_x;
			goal_y_s1   <= goal_y;
			marker_x_s1 <= marker_x;
			marker_y_s1 <= marker_y;
			pan_x_s1    <= pan_x;
			pan_y_s1    <= pan_y;
		end
	end

	// ---------------------------------------------------------------- frame decode
	// Priority: pad held, then disarmed/unsteerable, then no indicator, then steer.
	assign disarmed    = !armed_s1 || !steer_s1;
	assign closed_loop = !pad_s1 && !disarmed && found_s1;

	// every case except closed-loop steering clears both axes
	assign axis_ctl.step  = advance;
	assign axis_ctl.clear = !closed_loop;

	// probe count survives a held pad, drops on disarm, runs with no indicator
	assign probe_ctl.step  = advance;
	assign probe_ctl.clear = !pad_s1 && disarmed;
	assign probe_ctl.run   = !pad_s1 && !disarmed && !found_s1;

	assign err_x   = $signed({1'b0, goal_x_s1}) - $signed({1'b0, marker_x_s1});
	assign err_y   = $signed({1'b0, goal_y_s1}) - $signed({1'b0, marker_y_s1});
	assign world_x = {1'b0, marker_x_s1} + {1'b0, pan_x_s1};
	assign world_y = {1'b0, marker_y_s1} + {1'b0, pan_y_s1};

	pds_axis #(
		.BLOCK_COOLDOWN (BLOCK_COOLDOWN)
	) u_axis_x (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (axis_ctl),
		.cfg     (cfg_q),
		.err     (err_x),
		.world   (world_x),
		.key_dir (dir_x)
	);

	pds_axis #(
		.BLOCK_COOLDOWN (BLOCK_COOLDOWN)
	) u_axis_y (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (axis_ctl),
		.cfg     (cfg_q),
		.err     (err_y),
		.world   (world_y),
		.key_dir (dir_y)
	);

	pds_probe #(
		.CENTER_X (CENTER_X),
		.CENTER_Y (CENTER_Y)
	) u_probe (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (probe_ctl),
		.period (cfg_q.probe_period),
		.goal_x (goal_x_s1),
		.goal_y (goal_y_s1),
		.keys   (probe_keys)
	);

	// axis direction to key bits: x positive is right, y positive is down
	always_comb begin
		steer_keys = '0;
		if (dir_x == pds_pkg::DIR_POS) steer_keys = steer_keys | pds_pkg::KEY_RIGHT;
		if (dir_x == pds_pkg::DIR_NEG) steer_keys = steer_keys | pds_pkg::KEY_LEFT;
		if (dir_y == pds_pkg::DIR_POS) steer_keys = steer_keys | pds_pkg::KEY_DOWN;
		if (dir_y == pds_pkg::DIR_NEG) steer_keys = steer_keys | pds_pkg::KEY_UP;
	end

	// click keys always pass; axis and probe outputs are zero outside their own case
	assign keys = (clk_a_s1 ? pds_pkg::KEY_A : 6'h00)
	            | (clk_b_s1 ? pds_pkg::KEY_B : 6'h00)
	            | steer_keys | probe_keys;

	// ---------------------------------------------------------------- result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else if (advance)
			vld_s2 <= 1'b1;
		else if (out_ready)
			vld_s2 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			key_mask_s2 <= keys;
			active_s2   <= closed_loop;
		end
	end

	assign out_valid       = vld_s2;
	assign key_mask        = key_mask_s2;
	assign steering_active = active_s2;

	// ---------------------------------------------------------------- checks
	// never both directions on one axis
	a_axis_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> !(key_mask[2] && key_mask[3]) && !(key_mask[4] && key_mask[5]))
		else $error("opposing direction keys in one result");

	// open loop gives at most one direction (the probe pulse)
	a_open_loop_single: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && !steering_active) |-> $onehot0(key_mask[5:2]))
		else $error("more than one direction without closed-loop steering");

	// input stalls only when the stage is full and the result is held
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (vld_s1 && vld_s2 && !out_ready))
		else $error("input stalled without a held result");

	// a frame that advances always lands in the result register
	a_advance_lands: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> vld_s2)
		else $error("advanced frame lost");

endmodule
